// ===== rtl/core/hol_pkg.sv =====
package hol_pkg;

	localparam int BYTES_PER_LINE = 10;
	localparam int ADDRESS_BITS   = 12;
	localparam int BAR_COLUMN     = 28;

	localparam int DATA_COL  = 7;
	localparam int IDX_W     = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
	localparam int CNT_W     = $clog2(2 * BYTES_PER_LINE + 1);
	localparam int NB_W      = $clog2(BYTES_PER_LINE + 1);
	localparam int FREE_W    = ADDRESS_BITS + 1;
	localparam int SUM_W     = (ADDRESS_BITS + 1 > 13) ? ADDRESS_BITS + 1 : 13;
	localparam int LADDR_W   = 12;
	localparam int WADDR_W   = 12;
	localparam int LINE_W    = 16;
	localparam int TDATA_W   = 40;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_COLON   = 8'h3a;
	localparam logic [7:0] CH_BAR     = 8'h7c;

	// check flag bit positions
	localparam int F_NOT_BLANK   = 0;
	localparam int F_NOT_COMMENT = 1;
	localparam int F_BAR_BAD     = 2;
	localparam int F_HEAD_BAD    = 3;
	localparam int F_DATA_ENDED  = 4;
	localparam int F_DATA_BAD    = 5;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT,
		S_STATUS
	} state_t;

endpackage

// ===== rtl/core/hex_object_line_loader.sv =====
// Channel   Dir  tdata (low bit up)                                   tuser  tlast
// s_axis    in   character[7:0]                                       -      -
// m_axis    out  write_address[11:0] write_byte[19:12] line_number    kind   last
//                [35:20], zero pad [39:36]
// One character per cycle outside a newline; a non-newline never stalls input.
// A good line's newline blocks input while its data bytes drain, each through
// the line buffer's registered read port, and until its status loads.
// Output stalls hold the drain; the result register lets input resume while
// the status still waits. Reset (arst_n low) clears all control state.
module hex_object_line_loader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // character
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [hol_pkg::TDATA_W-1:0]   m_axis_tdata,   // write_address, write_byte,
	                                                      // line_number
	output logic [1:0]                    m_axis_tuser,   // kind
	output logic                          m_axis_tlast
);
	import hol_pkg::*;

	state_t state_q, state_d;

	logic [7:0]         column_q;
	logic [LADDR_W-1:0] line_address_q;
	logic [CNT_W-1:0]   digit_count_q;
	logic [7:0]         flags_q;
	logic [FREE_W-1:0]  next_free_q;
	logic [LINE_W-1:0]  line_counter_q;
	logic               halted_q;
	logic [3:0]         hi_nibble_q;

	logic [NB_W-1:0]    nbytes_q;
	logic [NB_W-1:0]    drain_idx_q;
	logic [LADDR_W-1:0] base_q;
	kind_t              status_kind_q;

	logic [7:0]         line_mem [BYTES_PER_LINE];
	logic [7:0]         rd_data_s1;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [WADDR_W-1:0] out_addr_q;
	logic [7:0]         out_byte_q;
	logic [LINE_W-1:0]  out_line_q;
	logic               out_last_q;

	logic in_fire, is_nl, slot_free;
	logic load_write, load_status;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign is_nl     = (s_axis_tdata == CH_NEWLINE);
	assign slot_free = !out_valid_q || m_axis_tready;

	// hex decode
	logic       hex_ok;
	logic [3:0] hex_v;
	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		if (s_axis_tdata >= 8'h30 && s_axis_tdata <= 8'h39) begin
			hex_v = 4'(s_axis_tdata - 8'h30);
		end else if (s_axis_tdata >= 8'h61 && s_axis_tdata <= 8'h66) begin
			hex_v = 4'(s_axis_tdata - 8'h57);
		end else if (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h46) begin
			hex_v = 4'(s_axis_tdata - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// per-character line checks
	logic [7:0]         flags_d;
	logic [LADDR_W-1:0] laddr_d;
	logic [CNT_W-1:0]   dcount_d;
	logic               mem_we, take_hi;
	logic               is_space;
	always_comb begin
		flags_d  = flags_q;
		laddr_d  = line_address_q;
		dcount_d = digit_count_q;
		mem_we   = 1'b0;
		take_hi  = 1'b0;
		is_space = (s_axis_tdata == CH_SPACE);
		if (!is_space) begin
			flags_d[F_NOT_BLANK] = 1'b1;
			if (column_q <= 8'(BAR_COLUMN - 2)) flags_d[F_NOT_COMMENT] = 1'b1;
		end
		if ((column_q == 8'(BAR_COLUMN - 1) && !is_space) ||
		    (column_q == 8'(BAR_COLUMN) && s_axis_tdata != CH_BAR) ||
		    (column_q == 8'(BAR_COLUMN + 1) && !is_space))
			flags_d[F_BAR_BAD] = 1'b1;
		if ((column_q == 8'd0 && s_axis_tdata != CH_ZERO) ||
		    (column_q == 8'd1 && s_axis_tdata != CH_X) ||
		    (column_q == 8'd5 && s_axis_tdata != CH_COLON) ||
		    (column_q == 8'd6 && !is_space))
			flags_d[F_HEAD_BAD] = 1'b1;
		if (column_q >= 8'd2 && column_q <= 8'd4) begin
			if (!hex_ok) flags_d[F_HEAD_BAD] = 1'b1;
			else laddr_d = {line_address_q[LADDR_W-5:0], hex_v};
		end
		if (column_q >= 8'(DATA_COL) && column_q <= 8'(BAR_COLUMN - 2)) begin
			if (is_space) begin
				flags_d[F_DATA_ENDED] = 1'b1;
			end else if (hex_ok && !flags_q[F_DATA_ENDED]) begin
				if (digit_count_q >= CNT_W'(2 * BYTES_PER_LINE)) begin
					flags_d[F_DATA_BAD] = 1'b1;
				end else begin
					mem_we   = digit_count_q[0];
					take_hi  = !digit_count_q[0];
					dcount_d = digit_count_q + 1'b1;
				end
			end else begin
				flags_d[F_DATA_BAD] = 1'b1;
			end
		end
	end

	// end-of-line verdict
	logic            tail_ok, line_ok;
	logic [NB_W-1:0] nb_eff;
	logic [SUM_W-1:0] end_addr;
	always_comb begin
		tail_ok  = !flags_q[F_BAR_BAD] && column_q >= 8'(BAR_COLUMN + 2);
		nb_eff   = NB_W'(digit_count_q >> 1);
		end_addr = SUM_W'(line_address_q) + SUM_W'(nb_eff);
		if (!flags_q[F_NOT_BLANK]) begin
			line_ok = 1'b1;
			nb_eff  = '0;
		end else if (!flags_q[F_NOT_COMMENT]) begin
			line_ok = tail_ok;
			nb_eff  = '0;
		end else begin
			line_ok = tail_ok && !flags_q[F_HEAD_BAD] && !flags_q[F_DATA_BAD] &&
			          !digit_count_q[0] &&
			          SUM_W'(line_address_q) >= SUM_W'(next_free_q) &&
			          end_addr <= SUM_W'(1 << ADDRESS_BITS);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && is_nl && !halted_q)
					state_d = (line_ok && nb_eff != '0) ? S_READ : S_STATUS;
			end
			S_READ: state_d = S_EMIT;
			S_EMIT: begin
				if (slot_free)
					state_d = (drain_idx_q == nbytes_q - 1'b1) ? S_STATUS : S_READ;
			end
			S_STATUS: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		load_write    = 1'b0;
		load_status   = 1'b0;
		unique case (state_q)
			S_IDLE:   s_axis_tready = 1'b1;
			S_READ:   ;
			S_EMIT:   load_write  = slot_free;
			S_STATUS: load_status = slot_free;
			default:  ;
		endcase
	end

	// line byte buffer
	always_ff @(posedge clk) begin
		if (in_fire && !is_nl && !halted_q && mem_we)
			line_mem[IDX_W'(digit_count_q >> 1)] <= {hi_nibble_q, hex_v};
		rd_data_s1 <= line_mem[drain_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_fire && !is_nl && !halted_q && take_hi) hi_nibble_q <= hex_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			column_q       <= '0;
			line_address_q <= '0;
			digit_count_q  <= '0;
			flags_q        <= '0;
			next_free_q    <= '0;
			line_counter_q <= LINE_W'(1);
			halted_q       <= 1'b0;
			nbytes_q       <= '0;
			drain_idx_q    <= '0;
			base_q         <= '0;
			status_kind_q  <= KIND_ACCEPT;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				if (is_nl) begin
					column_q       <= '0;
					line_address_q <= '0;
					digit_count_q  <= '0;
					flags_q        <= '0;
					if (!halted_q) begin
						nbytes_q      <= nb_eff;
						drain_idx_q   <= '0;
						base_q        <= line_address_q;
						status_kind_q <= line_ok ? KIND_ACCEPT : KIND_REJECT;
						if (!line_ok) halted_q <= 1'b1;
						if (line_ok && nb_eff != '0) next_free_q <= FREE_W'(end_addr);
					end
				end else if (!halted_q) begin
					line_address_q <= laddr_d;
					digit_count_q  <= dcount_d;
					flags_q        <= flags_d;
					if (column_q != 8'hff) column_q <= column_q + 1'b1;
				end
			end
			if (load_write) drain_idx_q <= drain_idx_q + 1'b1;
			if (load_status && status_kind_q == KIND_ACCEPT &&
			    line_counter_q != {LINE_W{1'b1}})
				line_counter_q <= line_counter_q + 1'b1;
			if (load_write || load_status) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_write) begin
			out_kind_q <= KIND_WRITE;
			out_addr_q <= WADDR_W'(base_q + LADDR_W'(drain_idx_q));
			out_byte_q <= rd_data_s1;
			out_line_q <= line_counter_q;
			out_last_q <= 1'b0;
		end else if (load_status) begin
			out_kind_q <= status_kind_q;
			out_addr_q <= '0;
			out_byte_q <= '0;
			out_line_q <= line_counter_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_line_q, out_byte_q, out_addr_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule
